[hw/rtl/first_fit_page_allocator_macros.svh]
// Assertion macros shared by the allocator RTL; they expect clk and arst_n in scope.
`ifndef FIRST_FIT_PAGE_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_MACROS_SVH
// Property that must hold at every clock edge outside reset.
`define FFPA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition in one cycle that implies another in the next cycle.
`define FFPA_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`endif

[hw/rtl/ffpa_pkg.sv]
// Shared constants and types of the first-fit page allocator.
package ffpa_pkg;
	localparam int PAGE_INDEX_BITS_DEF = 16;
	localparam int MAX_EXTENTS_DEF = 256;
	localparam int KEY_W = 32;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE = 2'd1;
	localparam logic [1:0] OP_ADD = 2'd2;
	localparam logic [1:0] OP_NOP = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_ZERO = 3'd1;
	localparam logic [2:0] ST_SHORT = 3'd2;
	localparam logic [2:0] ST_NOFIT = 3'd3;
	localparam logic [2:0] ST_FULL = 3'd4;

	localparam logic [1:0] SM_FIT = 2'd0;
	localparam logic [1:0] SM_MERGE = 2'd1;
	localparam logic [1:0] SM_RENUM = 2'd2;
	localparam logic [1:0] SM_SLOT = 2'd3;

	typedef struct packed {
		logic [1:0] mode;
		logic first;
	} scan_ctl_t;

	typedef struct packed {
		logic hit;
		logic hit_pred;
		logic slot_ok;
	} scan_res_t;
endpackage

[hw/rtl/ffpa_mem.sv]
// Extent table memory: one write port, one read port with registered data.
module ffpa_mem #(
	parameter int DW = 66,
	parameter int DEPTH = 256,
	parameter int AW = 8
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);
	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

[hw/rtl/ffpa_scan.sv]
// Scan unit: examines one table entry per cycle and keeps the best candidate and first free slot.
module ffpa_scan #(
	parameter int PAGE_INDEX_BITS = ffpa_pkg::PAGE_INDEX_BITS_DEF,
	parameter int MAX_EXTENTS = ffpa_pkg::MAX_EXTENTS_DEF
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              clr,
	input  logic                                              dv,
	input  logic [$clog2(MAX_EXTENTS)-1:0]                    didx,
	input  logic [2*PAGE_INDEX_BITS+ffpa_pkg::KEY_W+1:0]      dword,
	input  ffpa_pkg::scan_ctl_t                               ctl,
	input  logic [PAGE_INDEX_BITS:0]                          count,
	input  logic [ffpa_pkg::KEY_W-1:0]                        after,
	input  logic [PAGE_INDEX_BITS-1:0]                        cs,
	input  logic [PAGE_INDEX_BITS+$clog2(MAX_EXTENTS)+1:0]    cl,
	output ffpa_pkg::scan_res_t                               res,
	output logic [$clog2(MAX_EXTENTS)-1:0]                    best_idx,
	output logic [ffpa_pkg::KEY_W-1:0]                        best_key,
	output logic [PAGE_INDEX_BITS-1:0]                        best_start,
	output logic [PAGE_INDEX_BITS:0]                          best_len,
	output logic [$clog2(MAX_EXTENTS)-1:0]                    slot_idx
);
	localparam int PW = PAGE_INDEX_BITS;
	localparam int CW = PW + 1;
	localparam int IW = $clog2(MAX_EXTENTS);
	localparam int XW = CW + IW + 1;
	localparam int KW = ffpa_pkg::KEY_W;

	logic          v;
	logic [KW-1:0] k;
	logic [PW-1:0] st;
	logic [CW-1:0] ln;
	logic [XW:0]   cur_end;
	logic [CW:0]   ext_end;
	logic          succ;
	logic          pred;
	logic          after_ok;
	logic          newer;
	logic          cand;
	logic          hit_q;
	logic          pred_q;
	logic          slot_ok_q;

	assign {v, k, st, ln} = dword;
	assign cur_end = {{(XW + 1 - PW){1'b0}}, cs} + {1'b0, cl};
	assign ext_end = {2'b00, st} + {1'b0, ln};
	assign succ = (cur_end == {{(XW + 1 - PW){1'b0}}, st});
	assign pred = (ext_end == {2'b00, cs});
	assign after_ok = ctl.first || (k > after);
	assign newer = !hit_q || (k < best_key);

	always_comb begin
		unique case (ctl.mode)
			ffpa_pkg::SM_FIT:   cand = v && (ln >= count);
			ffpa_pkg::SM_MERGE: cand = v && after_ok && (succ || pred);
			ffpa_pkg::SM_RENUM: cand = v && after_ok;
			default:            cand = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
			pred_q <= 1'b0;
			slot_ok_q <= 1'b0;
		end else if (clr) begin
			hit_q <= 1'b0;
			pred_q <= 1'b0;
			slot_ok_q <= 1'b0;
		end else if (dv) begin
			if (cand && newer) begin
				hit_q <= 1'b1;
				pred_q <= !succ;
			end
			if (!v && !slot_ok_q) begin
				slot_ok_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dv && cand && newer) begin
			best_idx <= didx;
			best_key <= k;
			best_start <= st;
			best_len <= ln;
		end
		if (dv && !v && !slot_ok_q) begin
			slot_idx <= didx;
		end
	end

	assign res.hit = hit_q;
	assign res.hit_pred = pred_q;
	assign res.slot_ok = slot_ok_q;
endmodule

[hw/rtl/first_fit_page_allocator.sv]
// Top level of the first-fit page allocator: command sequencer around the extent table.
//
// Usage: drive operation, start_page and page_count and raise start; the beat is taken at
// the rising edge where start is high and busy is low. busy stays high until the result.
// The result (status, block_start, free_total) is shown for exactly one cycle with done
// high; the receiver cannot stall, so it must take the beat in that cycle.
// Every pass walks the whole extent table once through the single read port of the table
// memory, one entry per cycle.
// Allocate takes one pass; add takes one pass unless the order keys run out.
// Free takes one pass per extent merged plus one.
// Zero counts, shortage on allocate and the no-op code answer without a pass.
// When the order keys run out, a renumbering adds one pass per valid extent plus one.
// After reset the table is cleared entry by entry while busy is high; the free
// total and the order key start at zero.
`include "first_fit_page_allocator_macros.svh"

module first_fit_page_allocator #(
	parameter int PAGE_INDEX_BITS = ffpa_pkg::PAGE_INDEX_BITS_DEF,
	parameter int MAX_EXTENTS = ffpa_pkg::MAX_EXTENTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 operation,
	input  logic [PAGE_INDEX_BITS-1:0] start_page,
	input  logic [PAGE_INDEX_BITS:0]   page_count,
	output logic                       done,
	output logic [2:0]                 status,
	output logic [PAGE_INDEX_BITS-1:0] block_start,
	output logic [PAGE_INDEX_BITS:0]   free_total
);
	localparam int PW = PAGE_INDEX_BITS;
	localparam int CW = PW + 1;
	localparam int IW = $clog2(MAX_EXTENTS);
	localparam int XW = CW + IW + 1;
	localparam int KW = ffpa_pkg::KEY_W;
	localparam int DW = 1 + KW + PW + CW;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_WAIT = 3'd3;
	localparam logic [2:0] S_EVAL = 3'd4;
	localparam logic [2:0] S_RESP = 3'd5;

	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_EXTENTS - 1);
	localparam logic [KW-1:0] KEY_MAX = {KW{1'b1}};

	logic [2:0]    state_q;
	logic [IW-1:0] cnt_q;
	logic [1:0]    mode_q;
	logic          first_q;
	logic [KW-1:0] after_q;
	logic [KW-1:0] rank_q;
	logic [KW-1:0] next_key_q;
	logic [CW-1:0] free_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] len_q;
	logic [PW-1:0] cs_q;
	logic [XW-1:0] cl_q;
	logic [2:0]    status_q;
	logic [PW-1:0] block_q;
	logic          done_q;
	logic          dv_q;
	logic [IW-1:0] didx_q;

	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic [DW-1:0] wr_data;
	logic          rd_en;
	logic [DW-1:0] rd_data;
	logic          clr;

	ffpa_pkg::scan_ctl_t ctl;
	ffpa_pkg::scan_res_t res;
	logic [IW-1:0] best_idx;
	logic [KW-1:0] best_key;
	logic [PW-1:0] best_start;
	logic [CW-1:0] best_len;
	logic [IW-1:0] slot_idx;

	logic [CW-1:0] room;
	logic [CW-1:0] clip;
	logic [CW:0]   sum;
	logic [CW-1:0] free_add;
	logic [KW-1:0] app_key;
	logic [DW-1:0] app_word;
	logic          accept;

	assign accept = start && !busy;
	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign status = status_q;
	assign block_start = block_q;
	assign free_total = free_q;

	// Ranges that run past the last page are cut there.
	assign room = {1'b1, {PW{1'b0}}} - {1'b0, start_page};
	assign clip = (page_count > room) ? room : page_count;
	assign sum = {1'b0, free_q} + {1'b0, len_q};
	assign free_add = sum[CW] ? {CW{1'b1}} : sum[CW-1:0];

	assign app_key = (mode_q == ffpa_pkg::SM_RENUM) ? rank_q : next_key_q;
	assign app_word = {1'b1, app_key, cs_q, cl_q[CW-1:0]};

	assign ctl.mode = mode_q;
	assign ctl.first = first_q;
	assign rd_en = (state_q == S_SCAN);
	assign clr = (state_q == S_SCAN) && (cnt_q == '0);

	ffpa_mem #(
		.DW(DW),
		.DEPTH(MAX_EXTENTS),
		.AW(IW)
	) u_mem (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(cnt_q),
		.rd_data(rd_data)
	);

	ffpa_scan #(
		.PAGE_INDEX_BITS(PAGE_INDEX_BITS),
		.MAX_EXTENTS(MAX_EXTENTS)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.clr(clr),
		.dv(dv_q),
		.didx(didx_q),
		.dword(rd_data),
		.ctl(ctl),
		.count(count_q),
		.after(after_q),
		.cs(cs_q),
		.cl(cl_q),
		.res(res),
		.best_idx(best_idx),
		.best_key(best_key),
		.best_start(best_start),
		.best_len(best_len),
		.slot_idx(slot_idx)
	);

	// Table writes happen only outside a pass, so a read never meets a pending write.
	always_comb begin
		wr_en = 1'b0;
		wr_addr = slot_idx;
		wr_data = app_word;
		if (state_q == S_CLEAR) begin
			wr_en = 1'b1;
			wr_addr = cnt_q;
			wr_data = '0;
		end else if (state_q == S_EVAL) begin
			unique case (mode_q)
				ffpa_pkg::SM_FIT: begin
					if (res.hit) begin
						wr_en = 1'b1;
						wr_addr = best_idx;
						if (best_len > count_q) begin
							wr_data = {1'b1, best_key, best_start + count_q[PW-1:0],
								best_len - count_q};
						end else begin
							wr_data = '0;
						end
					end
				end
				ffpa_pkg::SM_RENUM: begin
					if (res.hit) begin
						wr_en = 1'b1;
						wr_addr = best_idx;
						wr_data = {1'b1, rank_q, best_start, best_len};
					end else begin
						wr_en = res.slot_ok;
					end
				end
				default: begin
					if (mode_q == ffpa_pkg::SM_MERGE && res.hit) begin
						wr_en = 1'b1;
						wr_addr = best_idx;
						wr_data = '0;
					end else begin
						wr_en = res.slot_ok && (next_key_q != KEY_MAX);
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q <= '0;
			mode_q <= ffpa_pkg::SM_SLOT;
			first_q <= 1'b1;
			rank_q <= '0;
			next_key_q <= '0;
			free_q <= '0;
			done_q <= 1'b0;
			dv_q <= 1'b0;
		end else begin
			done_q <= (state_q == S_RESP);
			dv_q <= rd_en;
			unique case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_IDX) begin
						cnt_q <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						first_q <= 1'b1;
						if (operation == ffpa_pkg::OP_NOP) begin
							state_q <= S_RESP;
						end else if (page_count == '0) begin
							state_q <= S_RESP;
						end else if (operation == ffpa_pkg::OP_ALLOC) begin
							if (page_count > free_q) begin
								state_q <= S_RESP;
							end else begin
								mode_q <= ffpa_pkg::SM_FIT;
								state_q <= S_SCAN;
							end
						end else begin
							mode_q <= (operation == ffpa_pkg::OP_FREE) ?
								ffpa_pkg::SM_MERGE : ffpa_pkg::SM_SLOT;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_IDX) begin
						cnt_q <= '0;
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					state_q <= S_RESP;
					unique case (mode_q)
						ffpa_pkg::SM_FIT: begin
							if (res.hit) begin
								free_q <= free_q - count_q;
							end
						end
						ffpa_pkg::SM_RENUM: begin
							if (res.hit) begin
								first_q <= 1'b0;
								rank_q <= rank_q + 1'b1;
								state_q <= S_SCAN;
							end else if (res.slot_ok) begin
								next_key_q <= rank_q + 1'b1;
								free_q <= free_add;
							end
						end
						default: begin
							if (mode_q == ffpa_pkg::SM_MERGE && res.hit) begin
								first_q <= 1'b0;
								state_q <= S_SCAN;
							end else if (res.slot_ok) begin
								if (next_key_q == KEY_MAX) begin
									// Keys exhausted: renumber the list 0, 1, 2, ... first.
									mode_q <= ffpa_pkg::SM_RENUM;
									first_q <= 1'b1;
									rank_q <= '0;
									state_q <= S_SCAN;
								end else begin
									next_key_q <= next_key_q + 1'b1;
									free_q <= free_add;
								end
							end
						end
					endcase
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		didx_q <= cnt_q;
		if (state_q == S_IDLE && start) begin
			count_q <= page_count;
			len_q <= clip;
			cs_q <= start_page;
			cl_q <= XW'(clip);
			block_q <= '0;
			if (operation == ffpa_pkg::OP_NOP) begin
				status_q <= ffpa_pkg::ST_OK;
			end else if (page_count == '0) begin
				status_q <= ffpa_pkg::ST_ZERO;
			end else if (operation == ffpa_pkg::OP_ALLOC && page_count > free_q) begin
				status_q <= ffpa_pkg::ST_SHORT;
			end else begin
				status_q <= ffpa_pkg::ST_OK;
			end
		end else if (state_q == S_EVAL) begin
			if (mode_q == ffpa_pkg::SM_FIT) begin
				if (res.hit) begin
					block_q <= best_start;
				end else begin
					status_q <= ffpa_pkg::ST_NOFIT;
				end
			end else if (mode_q == ffpa_pkg::SM_MERGE && res.hit) begin
				cl_q <= cl_q + XW'(best_len);
				after_q <= best_key;
				if (res.hit_pred) begin
					cs_q <= best_start;
				end
			end else if (mode_q == ffpa_pkg::SM_RENUM && res.hit) begin
				after_q <= best_key;
			end else if (!res.slot_ok) begin
				status_q <= ffpa_pkg::ST_FULL;
			end
		end
	end

	`FFPA_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe lasted more than one cycle")
	`FFPA_ASSERT_NEXT(a_accept_busy, accept, busy, "busy did not rise after accept")
	`FFPA_ASSERT(a_status_code, done |-> (status <= ffpa_pkg::ST_FULL), "status code out of range")
endmodule
